[design/i2w_pkg.sv]
// ----------------------------------------------------------------------------
// i2w_pkg: shared types, token codes and helpers
// Token codes for the word stream and the binary-to-BCD step used by the
// conversion pipeline.
// ----------------------------------------------------------------------------
package i2w_pkg;

  localparam int NUM_W     = 31;               // input number width
  localparam int WORD_W    = 5;                // token code width
  localparam int DIGITS    = 10;               // decimal digits for 2^31-1
  localparam int BCD_W     = 4 * DIGITS;
  localparam int BIN_W     = 32;               // number padded to steps per stage
  localparam int DD_STEPS  = 4;                // shift/add-3 steps per stage
  localparam int DD_STAGES = BIN_W / DD_STEPS;
  localparam int SLOTS     = 16;               // fixed token positions per number
  localparam int SLOT_W    = $clog2(SLOTS);

  typedef logic [3:0]        digit_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BCD_W-1:0]  bcd_t;

  localparam word_t TOK_ZERO      = 5'd0;
  localparam word_t TOK_TEEN_BASE = 5'd10;
  localparam word_t TOK_TENS_BASE = 5'd18;
  localparam word_t TOK_HUNDRED   = 5'd28;
  localparam word_t TOK_THOUSAND  = 5'd29;
  localparam word_t TOK_MILLION   = 5'd30;
  localparam word_t TOK_BILLION   = 5'd31;

  typedef struct packed {
    bcd_t             bcd;
    logic [BIN_W-1:0] bin;
  } dd_t;

  // One double-dabble step: add 3 to every digit >= 5, then shift left.
  function automatic dd_t dd_step(input dd_t x);
    dd_t  y;
    bcd_t adj;
    adj = x.bcd;
    for (int i = 0; i < DIGITS; i++) begin
      if (adj[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
      end
    end
    {y.bcd, y.bin} = {adj[BCD_W-2:0], x.bin, 1'b0};
    return y;
  endfunction

endpackage

[design/i2w_bcd.sv]
// ----------------------------------------------------------------------------
// i2w_bcd: pipelined binary-to-BCD converter
// Double-dabble over DD_STAGES register stages, DD_STEPS steps per stage,
// with valid bits and per-stage ready so a stall holds every stage.
// ----------------------------------------------------------------------------
module i2w_bcd (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [i2w_pkg::NUM_W-1:0] number,
  output logic                    out_valid,
  input  logic                    out_ready,
  output i2w_pkg::bcd_t           digits
);
  import i2w_pkg::*;

  logic [DD_STAGES-1:0] stg_valid;
  logic [DD_STAGES-1:0] stg_ready;
  logic [DD_STAGES-1:0] src_valid;
  dd_t                  stg_data [DD_STAGES];
  dd_t                  stg_next [DD_STAGES];
  logic                 digits_ok;

  // ready ripples back from the output
  always_comb begin
    stg_ready[DD_STAGES-1] = !stg_valid[DD_STAGES-1] || out_ready;
    for (int k = DD_STAGES - 2; k >= 0; k--) begin
      stg_ready[k] = !stg_valid[k] || stg_ready[k+1];
    end
  end

  always_comb begin
    dd_t tmp;
    for (int k = 0; k < DD_STAGES; k++) begin
      if (k == 0) begin
        tmp.bcd      = '0;
        tmp.bin      = {1'b0, number};
        src_valid[k] = in_valid;
      end else begin
        tmp          = stg_data[k-1];
        src_valid[k] = stg_valid[k-1];
      end
      for (int s = 0; s < DD_STEPS; s++) begin
        tmp = dd_step(tmp);
      end
      stg_next[k] = tmp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= '0;
    end else begin
      for (int k = 0; k < DD_STAGES; k++) begin
        if (stg_ready[k]) begin
          stg_valid[k] <= src_valid[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DD_STAGES; k++) begin
      if (stg_ready[k] && src_valid[k]) begin
        stg_data[k] <= stg_next[k];
      end
    end
  end

  assign in_ready  = stg_ready[0];
  assign out_valid = stg_valid[DD_STAGES-1];
  assign digits    = stg_data[DD_STAGES-1].bcd;

  always_comb begin
    digits_ok = 1'b1;
    for (int i = 0; i < DIGITS; i++) begin
      if (digits[4*i +: 4] > 4'd9) begin
        digits_ok = 1'b0;
      end
    end
  end

  a_digits_decimal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> digits_ok)
    else $error("BCD output holds a non-decimal digit");

  a_first_stage_load: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> stg_valid[0])
    else $error("accepted request did not reach first stage");

  a_first_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (stg_valid[0] && !stg_ready[0]) |=> (stg_valid[0] && $stable(stg_data[0])))
    else $error("stalled first stage lost or changed its data");

endmodule

[design/integer_to_english_word_tokens_top.sv]
// ----------------------------------------------------------------------------
// integer_to_english_word_tokens_top: integer to English word tokens
// Spells a 31-bit unsigned number as a stream of word tokens, most
// significant first, with the final token of each number flagged.
//
// Input channel: in_valid/in_ready with payload number. Output channel:
// out_valid/out_ready with payload word (token code) and last.
// A number gives 1 to 16 tokens (zero gives the single token Zero).
//
// Path: a request passes through 8 double-dabble stages, the slot stage,
// the token holder and the output reg; the accepting edge loads the first
// of them.
// Throughput: one token per cycle while out_ready is high; a number of n
// tokens holds the token holder until its last token is taken, so the
// single token output port sets the sustained rate. New requests enter
// every cycle until the pipeline fills, while earlier ones are spelled.
// Stall: when out_ready is low the output register and token holder hold;
// earlier stages keep closing bubbles, and in_ready drops only once the
// pipeline in front of the token holder is full. Nothing is lost.
// Reset (rst, synchronous) empties all stages; no state is kept between
// numbers.
// ----------------------------------------------------------------------------
module integer_to_english_word_tokens_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [i2w_pkg::NUM_W-1:0] number,
  output logic                      out_valid,
  input  logic                      out_ready,
  output i2w_pkg::word_t            word,
  output logic                      last
);
  import i2w_pkg::*;

  // one base-1000 group: hundreds digit, Hundred, tens/teen, ones, scale
  typedef struct packed {
    word_t [4:0] w;
    logic  [4:0] m;
  } grp_t;

  function automatic grp_t build_group(input digit_t h, input digit_t t,
                                       input digit_t o, input word_t scale);
    grp_t g;
    logic nz;
    nz     = (h != 4'd0) || (t != 4'd0) || (o != 4'd0);
    g.w[0] = {1'b0, h};
    g.m[0] = (h != 4'd0);
    g.w[1] = TOK_HUNDRED;
    g.m[1] = (h != 4'd0);
    if (t == 4'd1) begin
      g.w[2] = TOK_TEEN_BASE + {1'b0, o};
    end else begin
      g.w[2] = TOK_TENS_BASE + {1'b0, t};
    end
    g.m[2] = (t != 4'd0);
    g.w[3] = {1'b0, o};
    g.m[3] = (t != 4'd1) && (o != 4'd0);
    g.w[4] = scale;
    g.m[4] = nz;
    return g;
  endfunction

  // BCD pipeline
  logic bcd_valid;
  logic bcd_ready;
  bcd_t bcd;

  i2w_bcd u_bcd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .number    (number),
    .out_valid (bcd_valid),
    .out_ready (bcd_ready),
    .digits    (bcd)
  );

  // slot stage: tokens at fixed positions plus a presence mask
  logic             slot_valid;
  logic             slot_ready;
  word_t            slot_word [SLOTS];
  logic [SLOTS-1:0] slot_mask;
  word_t            slot_word_next [SLOTS];
  logic [SLOTS-1:0] slot_mask_next;

  // token holder: number being spelled
  logic             cur_valid;
  word_t            cur_word [SLOTS];
  logic [SLOTS-1:0] cur_mask;
  logic             cur_take;
  logic [SLOT_W-1:0] sel;
  logic [SLOTS-1:0] rest;
  logic             tok_load;
  logic             tok_last;

  always_comb begin
    grp_t bil;
    grp_t mil;
    grp_t thou;
    grp_t unit;
    bil  = build_group(4'd0, 4'd0, bcd[36 +: 4], TOK_BILLION);
    mil  = build_group(bcd[32 +: 4], bcd[28 +: 4], bcd[24 +: 4], TOK_MILLION);
    thou = build_group(bcd[20 +: 4], bcd[16 +: 4], bcd[12 +: 4], TOK_THOUSAND);
    unit = build_group(bcd[8 +: 4], bcd[4 +: 4], bcd[0 +: 4], TOK_ZERO);
    // billions: ones digit and scale only
    slot_word_next[0] = bil.w[3];
    slot_mask_next[0] = bil.m[3];
    slot_word_next[1] = bil.w[4];
    slot_mask_next[1] = bil.m[4];
    for (int j = 0; j < 5; j++) begin
      slot_word_next[2+j] = mil.w[j];
      slot_mask_next[2+j] = mil.m[j];
      slot_word_next[7+j] = thou.w[j];
      slot_mask_next[7+j] = thou.m[j];
    end
    // units: no scale word
    for (int j = 0; j < 4; j++) begin
      slot_word_next[12+j] = unit.w[j];
      slot_mask_next[12+j] = unit.m[j];
    end
    // whole number zero: units ones slot carries Zero
    if (bcd == '0) begin
      slot_mask_next[15] = 1'b1;
    end
  end

  // pick the lowest present slot
  always_comb begin
    sel = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (cur_mask[i]) begin
        sel = SLOT_W'(i);
      end
    end
  end

  assign rest       = cur_mask & (cur_mask - SLOTS'(1));
  assign tok_last   = (rest == '0);
  assign tok_load   = cur_valid && (!out_valid || out_ready);
  assign cur_take   = !cur_valid || (tok_load && tok_last);
  assign slot_ready = !slot_valid || cur_take;
  assign bcd_ready  = slot_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
      cur_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (slot_ready) begin
        slot_valid <= bcd_valid;
      end
      if (cur_take) begin
        cur_valid <= slot_valid;
      end
      if (!out_valid || out_ready) begin
        out_valid <= cur_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_ready && bcd_valid) begin
      slot_word <= slot_word_next;
      slot_mask <= slot_mask_next;
    end
    if (cur_take && slot_valid) begin
      cur_word <= slot_word;
      cur_mask <= slot_mask;
    end else if (tok_load) begin
      cur_mask <= rest;
    end
    if (tok_load) begin
      word <= cur_word[sel];
      last <= tok_last;
    end
  end

  a_cur_nonempty: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur_mask != '0))
    else $error("token holder valid with no tokens left");

  a_slot_nonempty: assert property (@(posedge clk) disable iff (rst)
    slot_valid |-> (slot_mask != '0))
    else $error("slot stage holds a number with no tokens");

  a_cur_continues: assert property (@(posedge clk) disable iff (rst)
    (tok_load && !tok_last) |=> cur_valid)
    else $error("token holder dropped a number before its last token");

endmodule

[tb/word_stream_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_stream_checker: token stream scoreboard for the number speller
// Watches both channels, spells every accepted number into its expected
// token run and compares each delivered token against the oldest one.
// ----------------------------------------------------------------------------
module word_stream_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [i2w_pkg::NUM_W-1:0] number,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  i2w_pkg::word_t            word,
  input  logic                      last,
  output int                        fail_count,
  output int                        tokens_pending
);
  import i2w_pkg::*;

  typedef struct packed {
    word_t word;
    logic  last;
  } token_t;

  token_t expected_tokens[$];

  // Appends the English token run of one number, last flag on its final token.
  function automatic void spell_number(input logic [NUM_W-1:0] value);
    token_t      run[$];
    int unsigned scale_div[4] = '{1, 1000, 1000000, 1000000000};
    int unsigned grp;
    int unsigned hund;
    int unsigned tens;
    int unsigned ones;
    if (value == '0) begin
      expected_tokens.push_back(token_t'{TOK_ZERO, 1'b1});
      return;
    end
    for (int g = 3; g >= 0; g--) begin
      grp = (value / scale_div[g]) % 1000;
      if (grp == 0) continue;  // empty groups say nothing, not even a scale word
      hund = grp / 100;
      tens = (grp / 10) % 10;
      ones = grp % 10;
      if (hund != 0) begin
        run.push_back(token_t'{word_t'(hund), 1'b0});
        run.push_back(token_t'{TOK_HUNDRED, 1'b0});
      end
      if (tens == 1) begin
        run.push_back(token_t'{TOK_TEEN_BASE + word_t'(ones), 1'b0});
      end else begin
        if (tens != 0) run.push_back(token_t'{TOK_TENS_BASE + word_t'(tens), 1'b0});
        if (ones != 0) run.push_back(token_t'{word_t'(ones), 1'b0});
      end
      case (g)
        3: run.push_back(token_t'{TOK_BILLION, 1'b0});
        2: run.push_back(token_t'{TOK_MILLION, 1'b0});
        1: run.push_back(token_t'{TOK_THOUSAND, 1'b0});
        default: ;
      endcase
    end
    run[run.size() - 1].last = 1'b1;
    foreach (run[i]) expected_tokens.push_back(run[i]);
  endfunction

  always @(posedge clk) begin
    token_t want;
    if (!rst) begin
      if (in_valid && in_ready) spell_number(number);
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected token word=%0d last=%0d", $time, word, last);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_tokens.pop_front();
          if (word !== want.word || last !== want.last) begin
            $display("%0t: token mismatch: expected word=%0d last=%0d, got word=%0d last=%0d",
                     $time, want.word, want.last, word, last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    tokens_pending <= expected_tokens.size();
  end

endmodule

[tb/integer_to_english_word_tokens_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_english_word_tokens_top_test: number speller testbench
// Drives numbers into the speller through three traffic phases (receiver
// sparse, sender sparse, full rate with a long output stall), the first
// opening with a short directed sweep; a side checker predicts the token runs.
// ----------------------------------------------------------------------------
module integer_to_english_word_tokens_top_test;
  import i2w_pkg::*;

  localparam int WATCHDOG_CYCLES  = 3000;  // well above the long output stall
  localparam int HOLD_CYCLES      = 400;   // long receiver hold-off
  localparam int RANDOM_PER_PHASE = 147;
  localparam int TAIL_CYCLES      = 30;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [NUM_W-1:0] number;
  logic             out_valid;
  logic             out_ready;
  word_t            word;
  logic             last;

  int send_idle_pct;    // percent of request slots left empty
  int recv_idle_pct;    // percent of cycles with out_ready low
  int hold_requests;    // bumped by stimulus to ask for a long output stall
  int holds_served;
  int idle_cycles = 0;  // cycles with no handshake on either side
  int fail_count;
  int tokens_pending;

  // Directed sweep: zero, single digits, teens, tens edges, hundreds, each
  // scale word alone, skipped zero groups and the largest input.
  int unsigned directed_numbers[] = '{
    0, 1, 9, 10, 11, 19, 20, 21, 99, 100, 101, 110, 999, 1000, 1001, 13014,
    1000000, 7000011, 1000000000, 1001001001, 2000000000, 1999999999,
    2147483647
  };

  integer_to_english_word_tokens_top dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .number   (number),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .word     (word),
    .last     (last)
  );

  word_stream_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .number        (number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .word          (word),
    .last          (last),
    .fail_count    (fail_count),
    .tokens_pending(tokens_pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Random number mix: full 31-bit values, lone groups, and numbers built
  // group by group with many zero groups so scale skipping gets exercised.
  function automatic logic [NUM_W-1:0] random_number();
    longint unsigned value;
    int unsigned     grp;
    case ($urandom_range(2))
      0: return NUM_W'($urandom);
      1: return NUM_W'($urandom_range(999));
      default: begin
        value = $urandom_range(2);
        for (int g = 0; g < 3; g++) begin
          grp = ($urandom_range(2) == 0) ? 0 : $urandom_range(999);
          value = value * 1000 + grp;
        end
        if (value > 64'd2147483647) value = value - 64'd1000000000;
        return NUM_W'(value);
      end
    endcase
  endfunction

  // Offer one request at a falling edge and hold it until accepted. in_valid
  // stays high on return so back-to-back requests never drop it.
  task automatic send_number(input logic [NUM_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    number   <= value;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted token has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (tokens_pending != 0) @(negedge clk);
  endtask

  // Receiver: random out_ready, plus a long hold-off whenever asked.
  initial begin
    out_ready    = 1'b0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_served++;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: ends the run if both channels go quiet for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    number        = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Phase 1: sender idles now and then, receiver mostly stalled.
    send_idle_pct <= 32;
    recv_idle_pct <= 80;
    foreach (directed_numbers[i]) send_number(NUM_W'(directed_numbers[i]));
    for (int i = 0; i < RANDOM_PER_PHASE; i++) send_number(random_number());
    // full pause: pipeline must empty completely before traffic resumes
    drain_results();

    // Phase 2: roles swapped, sender sparse, receiver mostly ready.
    send_idle_pct <= 80;
    recv_idle_pct <= 32;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) send_number(random_number());
    drain_results();

    // Phase 3: full rate both sides; one long output stall midway while
    // requests keep coming, so the pipeline fills and in_ready drops.
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      if (i == 20) hold_requests <= hold_requests + 1;
      send_number(random_number());
    end
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
design/i2w_pkg.sv
design/i2w_bcd.sv
design/integer_to_english_word_tokens_top.sv
tb/word_stream_checker.sv
tb/integer_to_english_word_tokens_top_test.sv
